### design/texture_mip_chain_offset_unit_defines.svh
// Assertion macros shared by the texture mip chain offset unit.
`ifndef TEXTURE_MIP_CHAIN_OFFSET_UNIT_DEFINES_SVH
`define TEXTURE_MIP_CHAIN_OFFSET_UNIT_DEFINES_SVH

// Same-cycle implication, checked on the rising edge of clk outside reset.
`define TMCO_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tmco same-cycle check failed");

// Next-cycle implication, checked on the rising edge of clk outside reset.
`define TMCO_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tmco next-cycle check failed");

`endif

### design/tmco_pkg.sv
// Shared widths, register indexes, reset values and sequencer states.
`timescale 1ns / 1ps

package tmco_pkg;

  localparam int MAX_MIPS  = 15;
  localparam int MIP_W     = 4;
  localparam int EXT_W     = 15;
  localparam int PAD_W     = 16;
  localparam int DEPTH_W   = 12;
  localparam int ARRAY_W   = 12;
  localparam int BS_W      = 5;
  localparam int BPP_W     = 8;
  localparam int ARR_IDX_W = 11;
  localparam int FACE_W    = 3;
  localparam int DIDX_W    = 11;
  localparam int WORD_W    = 32;
  localparam int MUL_B_W   = 16;
  localparam int TEX_IDX_W = 14;
  localparam int TEXS_W    = 15;
  localparam int ADDR_W    = 5;
  localparam int REG_IDX_W = 3;
  localparam int BIT_IDX_W = 4;

  localparam logic [REG_IDX_W-1:0] REG_TEX_WIDTH   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_TEX_HEIGHT  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_TEX_DEPTH   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_MIP_COUNT   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_ARRAY_COUNT = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_CUBE_MAP    = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_BLOCK_SIZE  = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_BPP         = 3'd7;

  localparam logic [EXT_W-1:0]   RST_TEX_WIDTH   = 15'd1;
  localparam logic [EXT_W-1:0]   RST_TEX_HEIGHT  = 15'd1;
  localparam logic [DEPTH_W-1:0] RST_TEX_DEPTH   = 12'd1;
  localparam logic [MIP_W-1:0]   RST_MIP_COUNT   = 4'd1;
  localparam logic [ARRAY_W-1:0] RST_ARRAY_COUNT = 12'd1;
  localparam logic               RST_CUBE_MAP    = 1'b0;
  localparam logic [BS_W-1:0]    RST_BLOCK_SIZE  = 5'd1;
  localparam logic [BPP_W-1:0]   RST_BPP         = 8'd32;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b000_0000_0001,
    S_REM   = 11'b000_0000_0010,
    S_EXT   = 11'b000_0000_0100,
    S_LINE  = 11'b000_0000_1000,
    S_SLICE = 11'b000_0001_0000,
    S_TEX   = 11'b000_0010_0000,
    S_ACC   = 11'b000_0100_0000,
    S_F0    = 11'b000_1000_0000,
    S_F1    = 11'b001_0000_0000,
    S_F2    = 11'b010_0000_0000,
    S_F3    = 11'b100_0000_0000
  } state_t;

endpackage

### design/tmco_ifs.sv
// Valid/ready channel interfaces for query beats and result beats.
`timescale 1ns / 1ps

interface tmco_in_if;
  logic                               valid;
  logic                               ready;
  logic [tmco_pkg::ARR_IDX_W-1:0]     array_index;
  logic [tmco_pkg::FACE_W-1:0]        face;
  logic [tmco_pkg::MIP_W-1:0]         mip_level;
  logic [tmco_pkg::DIDX_W-1:0]        depth_index;

  modport source (output valid, array_index, face, mip_level, depth_index, input ready);
  modport sink (input valid, array_index, face, mip_level, depth_index, output ready);
endinterface

interface tmco_out_if;
  logic                               valid;
  logic                               ready;
  logic [tmco_pkg::WORD_W-1:0]        data_offset;
  logic [tmco_pkg::WORD_W-1:0]        line_bytes;
  logic [tmco_pkg::WORD_W-1:0]        slice_bytes;
  logic [tmco_pkg::EXT_W-1:0]         padded_width;
  logic [tmco_pkg::EXT_W-1:0]         padded_height;
  logic [tmco_pkg::WORD_W-1:0]        total_bytes;

  modport source (output valid, data_offset, line_bytes, slice_bytes, padded_width,
                  padded_height, total_bytes, input ready);
  modport sink (input valid, data_offset, line_bytes, slice_bytes, padded_width,
                padded_height, total_bytes, output ready);
endinterface

### design/texture_mip_chain_offset_unit.sv
// Texture mip chain offset unit: byte layout answers for mipmapped, arrayed textures.
`timescale 1ns / 1ps
`include "texture_mip_chain_offset_unit_defines.svh"

// One query is handled at a time and in_chan.ready stays low while it runs. Restoring
// remainder steps, one per extent bit, find the block-padding remainders of every
// halved width and height. Each mip level then uses the single shared 32x16 multiplier
// three times plus one accumulate, and none are run when mip_count is zero. Closing
// states F0 to F3 build the data offset and total size on the same multiplier. The
// last closing state waits while the result register still holds a beat that has not
// been taken. The result register lets the next query start while the previous
// result beat is still waiting.
module texture_mip_chain_offset_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  tmco_in_if.sink                          in_chan,
  tmco_out_if.source                       out_chan,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [tmco_pkg::ADDR_W-1:0]      paddr,
  input  logic [tmco_pkg::WORD_W-1:0]      pwdata,
  output logic [tmco_pkg::WORD_W-1:0]      prdata,
  output logic                             pready
);

  logic [tmco_pkg::EXT_W-1:0]     tex_width_r;
  logic [tmco_pkg::EXT_W-1:0]     tex_height_r;
  logic [tmco_pkg::DEPTH_W-1:0]   tex_depth_r;
  logic [tmco_pkg::MIP_W-1:0]     mip_count_r;
  logic [tmco_pkg::ARRAY_W-1:0]   array_count_r;
  logic                           cube_map_r;
  logic [tmco_pkg::BS_W-1:0]      block_size_r;
  logic [tmco_pkg::BPP_W-1:0]     bpp_r;

  tmco_pkg::state_t               state_r;
  tmco_pkg::state_t               state_nxt;

  logic [tmco_pkg::ARR_IDX_W-1:0] arr_idx_r;
  logic [tmco_pkg::FACE_W-1:0]    face_r;
  logic [tmco_pkg::MIP_W-1:0]     lvl_r;
  logic [tmco_pkg::DIDX_W-1:0]    didx_r;

  logic [tmco_pkg::BIT_IDX_W-1:0] bit_r;
  logic [tmco_pkg::BS_W-1:0]      prw_r;
  logic [tmco_pkg::BS_W-1:0]      prh_r;
  logic [tmco_pkg::BS_W-1:0]      rem_w_r [tmco_pkg::EXT_W];
  logic [tmco_pkg::BS_W-1:0]      rem_h_r [tmco_pkg::EXT_W];

  logic [tmco_pkg::MIP_W-1:0]     mip_r;
  logic [tmco_pkg::PAD_W-1:0]     w_r;
  logic [tmco_pkg::PAD_W-1:0]     h_r;
  logic [tmco_pkg::DEPTH_W-1:0]   d_r;
  logic [tmco_pkg::WORD_W-1:0]    prod_r;
  logic [tmco_pkg::WORD_W-1:0]    chain_r;
  logic [tmco_pkg::WORD_W-1:0]    off_r;

  logic [tmco_pkg::WORD_W-1:0]    sel_line_r;
  logic [tmco_pkg::WORD_W-1:0]    sel_slice_r;
  logic [tmco_pkg::WORD_W-1:0]    sel_off_r;
  logic [tmco_pkg::EXT_W-1:0]     sel_w_r;
  logic [tmco_pkg::EXT_W-1:0]     sel_h_r;

  logic                           out_valid_r;
  logic [tmco_pkg::WORD_W-1:0]    data_offset_r;
  logic [tmco_pkg::WORD_W-1:0]    line_bytes_r;
  logic [tmco_pkg::WORD_W-1:0]    slice_bytes_r;
  logic [tmco_pkg::EXT_W-1:0]     padded_width_r;
  logic [tmco_pkg::EXT_W-1:0]     padded_height_r;
  logic [tmco_pkg::WORD_W-1:0]    total_bytes_r;

  logic                           cfg_wr;
  logic                           in_acc;
  logic                           out_load;
  logic [tmco_pkg::BS_W-1:0]      bs_eff;
  logic [tmco_pkg::MIP_W-1:0]     mips_eff;
  logic [tmco_pkg::ARRAY_W-1:0]   arrays;
  logic [tmco_pkg::TEXS_W-1:0]    textures;
  logic [tmco_pkg::TEX_IDX_W-1:0] tex_idx;
  logic [tmco_pkg::BS_W:0]        rw_try;
  logic [tmco_pkg::BS_W:0]        rh_try;
  logic [tmco_pkg::BS_W:0]        rw_new;
  logic [tmco_pkg::BS_W:0]        rh_new;
  logic                           last_mip;
  logic                           is_sel;
  logic [tmco_pkg::MIP_W-1:0]     ext_idx;
  logic [tmco_pkg::EXT_W-1:0]     vw;
  logic [tmco_pkg::EXT_W-1:0]     vh;
  logic [tmco_pkg::DEPTH_W-1:0]   vd;
  logic [tmco_pkg::BS_W-1:0]      rw_sel;
  logic [tmco_pkg::BS_W-1:0]      rh_sel;
  logic [tmco_pkg::PAD_W-1:0]     pw;
  logic [tmco_pkg::PAD_W-1:0]     ph;
  logic [tmco_pkg::DEPTH_W-1:0]   pd;
  logic [tmco_pkg::WORD_W-1:0]    mul_a;
  logic [tmco_pkg::MUL_B_W-1:0]   mul_b;
  logic [tmco_pkg::WORD_W+tmco_pkg::MUL_B_W-1:0] mul_full;
  logic                           mul_en;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tex_width_r   <= tmco_pkg::RST_TEX_WIDTH;
      tex_height_r  <= tmco_pkg::RST_TEX_HEIGHT;
      tex_depth_r   <= tmco_pkg::RST_TEX_DEPTH;
      mip_count_r   <= tmco_pkg::RST_MIP_COUNT;
      array_count_r <= tmco_pkg::RST_ARRAY_COUNT;
      cube_map_r    <= tmco_pkg::RST_CUBE_MAP;
      block_size_r  <= tmco_pkg::RST_BLOCK_SIZE;
      bpp_r         <= tmco_pkg::RST_BPP;
    end else if (cfg_wr) begin
      case (paddr[tmco_pkg::ADDR_W-1:2])
        tmco_pkg::REG_TEX_WIDTH:   tex_width_r   <= pwdata[tmco_pkg::EXT_W-1:0];
        tmco_pkg::REG_TEX_HEIGHT:  tex_height_r  <= pwdata[tmco_pkg::EXT_W-1:0];
        tmco_pkg::REG_TEX_DEPTH:   tex_depth_r   <= pwdata[tmco_pkg::DEPTH_W-1:0];
        tmco_pkg::REG_MIP_COUNT:   mip_count_r   <= pwdata[tmco_pkg::MIP_W-1:0];
        tmco_pkg::REG_ARRAY_COUNT: array_count_r <= pwdata[tmco_pkg::ARRAY_W-1:0];
        tmco_pkg::REG_CUBE_MAP:    cube_map_r    <= pwdata[0];
        tmco_pkg::REG_BLOCK_SIZE:  block_size_r  <= pwdata[tmco_pkg::BS_W-1:0];
        tmco_pkg::REG_BPP:         bpp_r         <= pwdata[tmco_pkg::BPP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[tmco_pkg::ADDR_W-1:2])
      tmco_pkg::REG_TEX_WIDTH:   prdata = tmco_pkg::WORD_W'(tex_width_r);
      tmco_pkg::REG_TEX_HEIGHT:  prdata = tmco_pkg::WORD_W'(tex_height_r);
      tmco_pkg::REG_TEX_DEPTH:   prdata = tmco_pkg::WORD_W'(tex_depth_r);
      tmco_pkg::REG_MIP_COUNT:   prdata = tmco_pkg::WORD_W'(mip_count_r);
      tmco_pkg::REG_ARRAY_COUNT: prdata = tmco_pkg::WORD_W'(array_count_r);
      tmco_pkg::REG_CUBE_MAP:    prdata = tmco_pkg::WORD_W'(cube_map_r);
      tmco_pkg::REG_BLOCK_SIZE:  prdata = tmco_pkg::WORD_W'(block_size_r);
      tmco_pkg::REG_BPP:         prdata = tmco_pkg::WORD_W'(bpp_r);
      default:                   prdata = '0;
    endcase
  end

  assign bs_eff   = (block_size_r == '0) ? tmco_pkg::BS_W'(1) : block_size_r;
  assign mips_eff = (mip_count_r > tmco_pkg::MIP_W'(tmco_pkg::MAX_MIPS)) ?
                    tmco_pkg::MIP_W'(tmco_pkg::MAX_MIPS) : mip_count_r;
  assign arrays   = (array_count_r == '0) ? tmco_pkg::ARRAY_W'(1) : array_count_r;
  assign textures = cube_map_r ?
                    tmco_pkg::TEXS_W'({arrays, 2'b00}) + tmco_pkg::TEXS_W'({arrays, 1'b0}) :
                    tmco_pkg::TEXS_W'(arrays);
  assign tex_idx  = cube_map_r ?
                    tmco_pkg::TEX_IDX_W'({arr_idx_r, 2'b00}) +
                    tmco_pkg::TEX_IDX_W'({arr_idx_r, 1'b0}) + tmco_pkg::TEX_IDX_W'(face_r) :
                    tmco_pkg::TEX_IDX_W'(arr_idx_r) + tmco_pkg::TEX_IDX_W'(face_r);

  // Restoring remainder step, MSB first: after bit i the partial remainder is
  // (extent >> i) mod block size, so one pass yields the remainder for every mip.
  assign rw_try = {prw_r, tex_width_r[bit_r]};
  assign rh_try = {prh_r, tex_height_r[bit_r]};
  assign rw_new = (rw_try >= {1'b0, bs_eff}) ? rw_try - {1'b0, bs_eff} : rw_try;
  assign rh_new = (rh_try >= {1'b0, bs_eff}) ? rh_try - {1'b0, bs_eff} : rh_try;

  assign last_mip = ((mip_r + tmco_pkg::MIP_W'(1)) == mips_eff);
  assign is_sel   = (mip_r == lvl_r);
  assign ext_idx  = (state_r == tmco_pkg::S_ACC && !last_mip) ?
                    mip_r + tmco_pkg::MIP_W'(1) : mip_r;

  assign vw     = tex_width_r >> ext_idx;
  assign vh     = tex_height_r >> ext_idx;
  assign vd     = tex_depth_r >> ext_idx;
  assign rw_sel = rem_w_r[ext_idx];
  assign rh_sel = rem_h_r[ext_idx];

  always_comb begin
    if (vw == '0) begin
      pw = tmco_pkg::PAD_W'(bs_eff);
    end else if (rw_sel == '0) begin
      pw = tmco_pkg::PAD_W'(vw);
    end else begin
      pw = tmco_pkg::PAD_W'(vw) + tmco_pkg::PAD_W'(bs_eff) - tmco_pkg::PAD_W'(rw_sel);
    end
    if (vh == '0) begin
      ph = tmco_pkg::PAD_W'(bs_eff);
    end else if (rh_sel == '0) begin
      ph = tmco_pkg::PAD_W'(vh);
    end else begin
      ph = tmco_pkg::PAD_W'(vh) + tmco_pkg::PAD_W'(bs_eff) - tmco_pkg::PAD_W'(rh_sel);
    end
    pd = (vd == '0) ? tmco_pkg::DEPTH_W'(1) : vd;
  end

  always_comb begin
    mul_en = 1'b1;
    case (state_r)
      tmco_pkg::S_LINE: begin
        mul_a = tmco_pkg::WORD_W'(w_r);
        mul_b = tmco_pkg::MUL_B_W'(bpp_r);
      end
      tmco_pkg::S_SLICE: begin
        mul_a = tmco_pkg::WORD_W'(prod_r[23:3]);
        mul_b = h_r;
      end
      tmco_pkg::S_TEX: begin
        mul_a = prod_r;
        mul_b = tmco_pkg::MUL_B_W'(d_r);
      end
      tmco_pkg::S_F0: begin
        mul_a = chain_r;
        mul_b = tmco_pkg::MUL_B_W'(tex_idx);
      end
      tmco_pkg::S_F1: begin
        mul_a = sel_slice_r;
        mul_b = tmco_pkg::MUL_B_W'(didx_r);
      end
      tmco_pkg::S_F2: begin
        mul_a = chain_r;
        mul_b = tmco_pkg::MUL_B_W'(textures);
      end
      default: begin
        mul_en = 1'b0;
        mul_a  = '0;
        mul_b  = '0;
      end
    endcase
  end

  assign mul_full = (tmco_pkg::WORD_W+tmco_pkg::MUL_B_W)'(mul_a) *
                    (tmco_pkg::WORD_W+tmco_pkg::MUL_B_W)'(mul_b);

  assign in_chan.ready = (state_r == tmco_pkg::S_IDLE);
  assign in_acc        = in_chan.valid && in_chan.ready;
  assign out_load      = (state_r == tmco_pkg::S_F3) && (!out_valid_r || out_chan.ready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tmco_pkg::S_IDLE:  if (in_acc) state_nxt = tmco_pkg::S_REM;
      tmco_pkg::S_REM: begin
        if (bit_r == '0) begin
          state_nxt = (mips_eff == '0) ? tmco_pkg::S_F0 : tmco_pkg::S_EXT;
        end
      end
      tmco_pkg::S_EXT:   state_nxt = tmco_pkg::S_LINE;
      tmco_pkg::S_LINE:  state_nxt = tmco_pkg::S_SLICE;
      tmco_pkg::S_SLICE: state_nxt = tmco_pkg::S_TEX;
      tmco_pkg::S_TEX:   state_nxt = tmco_pkg::S_ACC;
      tmco_pkg::S_ACC:   state_nxt = last_mip ? tmco_pkg::S_F0 : tmco_pkg::S_LINE;
      tmco_pkg::S_F0:    state_nxt = tmco_pkg::S_F1;
      tmco_pkg::S_F1:    state_nxt = tmco_pkg::S_F2;
      tmco_pkg::S_F2:    state_nxt = tmco_pkg::S_F3;
      tmco_pkg::S_F3:    if (out_load) state_nxt = tmco_pkg::S_IDLE;
      default:           state_nxt = tmco_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tmco_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod_r <= mul_full[tmco_pkg::WORD_W-1:0];
    end
    case (state_r)
      tmco_pkg::S_IDLE: begin
        if (in_acc) begin
          arr_idx_r   <= in_chan.array_index;
          face_r      <= in_chan.face;
          lvl_r       <= in_chan.mip_level;
          didx_r      <= in_chan.depth_index;
          bit_r       <= tmco_pkg::BIT_IDX_W'(tmco_pkg::EXT_W - 1);
          prw_r       <= '0;
          prh_r       <= '0;
          mip_r       <= '0;
          chain_r     <= '0;
          sel_line_r  <= '0;
          sel_slice_r <= '0;
          sel_off_r   <= '0;
          sel_w_r     <= '0;
          sel_h_r     <= '0;
        end
      end
      tmco_pkg::S_REM: begin
        rem_w_r[bit_r] <= rw_new[tmco_pkg::BS_W-1:0];
        rem_h_r[bit_r] <= rh_new[tmco_pkg::BS_W-1:0];
        prw_r          <= rw_new[tmco_pkg::BS_W-1:0];
        prh_r          <= rh_new[tmco_pkg::BS_W-1:0];
        bit_r          <= bit_r - tmco_pkg::BIT_IDX_W'(1);
      end
      tmco_pkg::S_EXT: begin
        w_r <= pw;
        h_r <= ph;
        d_r <= pd;
      end
      tmco_pkg::S_SLICE: begin
        if (is_sel) begin
          sel_line_r <= tmco_pkg::WORD_W'(prod_r[23:3]);
          sel_w_r    <= w_r[tmco_pkg::EXT_W-1:0];
          sel_h_r    <= h_r[tmco_pkg::EXT_W-1:0];
          sel_off_r  <= chain_r;
        end
      end
      tmco_pkg::S_TEX: begin
        if (is_sel) begin
          sel_slice_r <= prod_r;
        end
      end
      tmco_pkg::S_ACC: begin
        chain_r <= chain_r + prod_r;
        mip_r   <= mip_r + tmco_pkg::MIP_W'(1);
        w_r     <= pw;
        h_r     <= ph;
        d_r     <= pd;
      end
      tmco_pkg::S_F1: begin
        off_r <= prod_r + sel_off_r;
      end
      tmco_pkg::S_F2: begin
        off_r <= off_r + prod_r;
      end
      tmco_pkg::S_F3: begin
        if (out_load) begin
          data_offset_r   <= off_r;
          line_bytes_r    <= sel_line_r;
          slice_bytes_r   <= sel_slice_r;
          padded_width_r  <= sel_w_r;
          padded_height_r <= sel_h_r;
          total_bytes_r   <= prod_r;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.data_offset   = data_offset_r;
  assign out_chan.line_bytes    = line_bytes_r;
  assign out_chan.slice_bytes   = slice_bytes_r;
  assign out_chan.padded_width  = padded_width_r;
  assign out_chan.padded_height = padded_height_r;
  assign out_chan.total_bytes   = total_bytes_r;

  `TMCO_ASSERT_NEXT(a_accept_starts_rem, in_acc, state_r == tmco_pkg::S_REM)
  `TMCO_ASSERT_IMPL(a_out_from_fin, $rose(out_valid_r), $past(state_r) == tmco_pkg::S_F3)
  `TMCO_ASSERT_IMPL(a_mip_in_range, state_r == tmco_pkg::S_LINE, mip_r < mips_eff)
  `TMCO_ASSERT_IMPL(a_unused_level_zero,
                    (state_r == tmco_pkg::S_F3) && (lvl_r >= mips_eff),
                    (sel_line_r == '0) && (sel_w_r == '0) && (sel_off_r == '0))

endmodule

### tb/texture_mip_chain_offset_unit_tb.sv
// Testbench for the texture mip chain offset unit: directed and random queries checked.
`timescale 1ns / 1ps

module texture_mip_chain_offset_unit_tb;

  localparam int HOLD_OFF_CYCLES = 400;
  localparam int STALL_LIMIT     = 3000;
  localparam int RANDOM_PHASES   = 9;
  localparam int ITEMS_PER_PHASE = 50;

  typedef struct packed {
    logic [tmco_pkg::ARR_IDX_W-1:0] array_index;
    logic [tmco_pkg::FACE_W-1:0]    face;
    logic [tmco_pkg::MIP_W-1:0]     mip_level;
    logic [tmco_pkg::DIDX_W-1:0]    depth_index;
  } query_t;

  typedef struct packed {
    logic [tmco_pkg::WORD_W-1:0] data_offset;
    logic [tmco_pkg::WORD_W-1:0] line_bytes;
    logic [tmco_pkg::WORD_W-1:0] slice_bytes;
    logic [tmco_pkg::EXT_W-1:0]  padded_width;
    logic [tmco_pkg::EXT_W-1:0]  padded_height;
    logic [tmco_pkg::WORD_W-1:0] total_bytes;
  } layout_t;

  typedef struct packed {
    logic [tmco_pkg::EXT_W-1:0]   width;
    logic [tmco_pkg::EXT_W-1:0]   height;
    logic [tmco_pkg::DEPTH_W-1:0] depth;
    logic [tmco_pkg::MIP_W-1:0]   mips;
    logic [tmco_pkg::ARRAY_W-1:0] arrays;
    logic                         cube;
    logic [tmco_pkg::BS_W-1:0]    block;
    logic [tmco_pkg::BPP_W-1:0]   bpp;
  } texture_cfg_t;

  typedef struct packed {
    logic [2:0] setting;
    query_t     query;
    logic       typed;
    layout_t    layout;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [tmco_pkg::ADDR_W-1:0] paddr;
  logic [tmco_pkg::WORD_W-1:0] pwdata;
  logic [tmco_pkg::WORD_W-1:0] prdata;
  logic pready;

  tmco_in_if  query_if ();
  tmco_out_if layout_if ();

  texture_mip_chain_offset_unit DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (query_if),
    .out_chan (layout_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  texture_cfg_t tex_cfg;
  layout_t      layout_q[$];
  stim_row_t    directed_rows[$];
  texture_cfg_t cfg_table[6];
  int           mismatch_count = 0;
  int           idle_cycles = 0;
  logic         hold_armed = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [31:0] halved_extent(logic [31:0] base, int level);
    logic [31:0] r;
    r = base >> level;
    return (r == 32'd0) ? 32'd1 : r;
  endfunction

  function automatic logic [31:0] round_to_block(logic [31:0] v, logic [31:0] bs);
    return ((v + bs - 32'd1) / bs) * bs;
  endfunction

  function automatic layout_t predict_layout(texture_cfg_t c, query_t q);
    logic [31:0] arrays, faces, bs, mips, chain, w, h, d, line, slice, tex;
    logic [31:0] sel_line, sel_slice, sel_w, sel_h, sel_off;
    layout_t r;
    arrays = (c.arrays == '0) ? 32'd1 : 32'(c.arrays);
    faces  = c.cube ? 32'd6 : 32'd1;
    bs     = (c.block == '0) ? 32'd1 : 32'(c.block);
    mips   = (32'(c.mips) > 32'(tmco_pkg::MAX_MIPS)) ? 32'(tmco_pkg::MAX_MIPS) : 32'(c.mips);
    chain = '0;
    sel_line = '0;
    sel_slice = '0;
    sel_w = '0;
    sel_h = '0;
    sel_off = '0;
    for (int i = 0; i < int'(mips); i++) begin
      w = round_to_block(halved_extent(32'(c.width), i), bs);
      h = round_to_block(halved_extent(32'(c.height), i), bs);
      d = halved_extent(32'(c.depth), i);
      line = (w * 32'(c.bpp)) / 32'd8;
      slice = line * h;
      if (i == int'(q.mip_level)) begin
        sel_line = line;
        sel_slice = slice;
        sel_w = w;
        sel_h = h;
        sel_off = chain;
      end
      chain = chain + slice * d;
    end
    tex = faces * 32'(q.array_index) + 32'(q.face);
    r.data_offset   = tex * chain + sel_off + sel_slice * 32'(q.depth_index);
    r.line_bytes    = sel_line;
    r.slice_bytes   = sel_slice;
    r.padded_width  = sel_w[tmco_pkg::EXT_W-1:0];
    r.padded_height = sel_h[tmco_pkg::EXT_W-1:0];
    r.total_bytes   = chain * faces * arrays;
    return r;
  endfunction

  function automatic logic [tmco_pkg::EXT_W-1:0] pick_extent();
    case ($urandom_range(0, 4))
      0: return tmco_pkg::EXT_W'(1);
      1: return tmco_pkg::EXT_W'(16384);
      2: return tmco_pkg::EXT_W'($urandom);
      default: return tmco_pkg::EXT_W'($urandom_range(1, 600));
    endcase
  endfunction

  function automatic texture_cfg_t random_setting();
    texture_cfg_t c;
    c.width  = pick_extent();
    c.height = pick_extent();
    case ($urandom_range(0, 3))
      0: c.depth = tmco_pkg::DEPTH_W'(1);
      1: c.depth = tmco_pkg::DEPTH_W'(2048);
      2: c.depth = tmco_pkg::DEPTH_W'($urandom);
      default: c.depth = tmco_pkg::DEPTH_W'($urandom_range(1, 16));
    endcase
    c.mips = tmco_pkg::MIP_W'($urandom);
    case ($urandom_range(0, 3))
      0: c.arrays = '0;
      1: c.arrays = tmco_pkg::ARRAY_W'(2048);
      2: c.arrays = tmco_pkg::ARRAY_W'($urandom);
      default: c.arrays = tmco_pkg::ARRAY_W'($urandom_range(1, 8));
    endcase
    c.cube  = 1'($urandom);
    c.block = ($urandom_range(0, 1) == 0) ? tmco_pkg::BS_W'(1 << $urandom_range(0, 4)) :
                                            tmco_pkg::BS_W'($urandom);
    c.bpp   = ($urandom_range(0, 1) == 0) ? tmco_pkg::BPP_W'(8 << $urandom_range(0, 4)) :
                                            tmco_pkg::BPP_W'($urandom);
    return c;
  endfunction

  function automatic query_t random_query(texture_cfg_t c);
    query_t q;
    int arrays, mips, slices;
    arrays = (c.arrays == '0) ? 1 : int'(c.arrays);
    mips = int'(c.mips);
    q.array_index = tmco_pkg::ARR_IDX_W'($urandom);
    q.face        = tmco_pkg::FACE_W'($urandom);
    q.mip_level   = tmco_pkg::MIP_W'($urandom);
    q.depth_index = tmco_pkg::DIDX_W'($urandom);
    if ($urandom_range(0, 9) < 8) begin
      q.array_index = tmco_pkg::ARR_IDX_W'($urandom_range(0, (arrays > 2048) ? 2047 : arrays - 1));
      q.face = c.cube ? tmco_pkg::FACE_W'($urandom_range(0, 5)) : '0;
      if (mips > 0) q.mip_level = tmco_pkg::MIP_W'($urandom_range(0, mips - 1));
      slices = int'(halved_extent(32'(c.depth), int'(q.mip_level)));
      q.depth_index = tmco_pkg::DIDX_W'($urandom_range(0, (slices > 2048) ? 2047 : slices - 1));
    end
    return q;
  endfunction

  function automatic stim_row_t mk_row(int setting, int ai, int fc, int ml, int di, bit typed,
                                       logic [31:0] off = 0, logic [31:0] line = 0,
                                       logic [31:0] slice = 0, logic [31:0] pw = 0,
                                       logic [31:0] ph = 0, logic [31:0] total = 0);
    stim_row_t r;
    r.setting = 3'(setting);
    r.query = '{tmco_pkg::ARR_IDX_W'(ai), tmco_pkg::FACE_W'(fc), tmco_pkg::MIP_W'(ml),
                tmco_pkg::DIDX_W'(di)};
    r.typed = typed;
    r.layout = '{off, line, slice, pw[tmco_pkg::EXT_W-1:0], ph[tmco_pkg::EXT_W-1:0], total};
    return r;
  endfunction

  task automatic note_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatch_count++;
    $display("MISMATCH %s: got 0x%08h, expected 0x%08h at %0t", what, got, want, $time);
  endtask

  task automatic write_reg(logic [tmco_pkg::REG_IDX_W-1:0] idx,
                           logic [tmco_pkg::WORD_W-1:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      tmco_pkg::REG_TEX_WIDTH:   tex_cfg.width  = value[tmco_pkg::EXT_W-1:0];
      tmco_pkg::REG_TEX_HEIGHT:  tex_cfg.height = value[tmco_pkg::EXT_W-1:0];
      tmco_pkg::REG_TEX_DEPTH:   tex_cfg.depth  = value[tmco_pkg::DEPTH_W-1:0];
      tmco_pkg::REG_MIP_COUNT:   tex_cfg.mips   = value[tmco_pkg::MIP_W-1:0];
      tmco_pkg::REG_ARRAY_COUNT: tex_cfg.arrays = value[tmco_pkg::ARRAY_W-1:0];
      tmco_pkg::REG_CUBE_MAP:    tex_cfg.cube   = value[0];
      tmco_pkg::REG_BLOCK_SIZE:  tex_cfg.block  = value[tmco_pkg::BS_W-1:0];
      tmco_pkg::REG_BPP:         tex_cfg.bpp    = value[tmco_pkg::BPP_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic apply_setting(texture_cfg_t c);
    write_reg(tmco_pkg::REG_TEX_WIDTH, 32'(c.width));
    write_reg(tmco_pkg::REG_TEX_HEIGHT, 32'(c.height));
    write_reg(tmco_pkg::REG_TEX_DEPTH, 32'(c.depth));
    write_reg(tmco_pkg::REG_MIP_COUNT, 32'(c.mips));
    write_reg(tmco_pkg::REG_ARRAY_COUNT, 32'(c.arrays));
    write_reg(tmco_pkg::REG_CUBE_MAP, 32'(c.cube));
    write_reg(tmco_pkg::REG_BLOCK_SIZE, 32'(c.block));
    write_reg(tmco_pkg::REG_BPP, 32'(c.bpp));
  endtask

  task automatic offer_query(query_t q, logic typed, layout_t typed_layout);
    @(negedge clk);
    query_if.valid <= 1'b1;
    query_if.array_index <= q.array_index;
    query_if.face <= q.face;
    query_if.mip_level <= q.mip_level;
    query_if.depth_index <= q.depth_index;
    @(posedge clk);
    while (!query_if.ready) @(posedge clk);
    layout_q.push_back(typed ? typed_layout : predict_layout(tex_cfg, q));
  endtask

  task automatic pause_sender(int cycles);
    if (cycles > 0) begin
      @(negedge clk);
      query_if.valid <= 1'b0;
      repeat (cycles - 1) @(negedge clk);
    end
  endtask

  task automatic settle();
    pause_sender(1);
    while (layout_q.size() != 0) @(posedge clk);
  endtask

  initial begin
    int phase_cycle, hold_left;
    logic hold_taken;
    phase_cycle = 0;
    hold_left = 0;
    hold_taken = 1'b0;
    layout_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      phase_cycle++;
      if (hold_armed && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        layout_if.ready <= 1'b0;
      end else begin
        case ((phase_cycle / 150) % 4)
          0: layout_if.ready <= 1'b1;
          1: layout_if.ready <= ($urandom_range(0, 3) != 0);
          2: layout_if.ready <= 1'($urandom_range(0, 1));
          default: layout_if.ready <= ((phase_cycle % 23) >= 9);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    layout_t want;
    if (rst_n && layout_if.valid && layout_if.ready) begin
      if (layout_q.size() == 0) begin
        note_mismatch("result beat with no query pending", layout_if.data_offset, '0);
      end else begin
        want = layout_q.pop_front();
        if (layout_if.data_offset !== want.data_offset)
          note_mismatch("data_offset", layout_if.data_offset, want.data_offset);
        if (layout_if.line_bytes !== want.line_bytes)
          note_mismatch("line_bytes", layout_if.line_bytes, want.line_bytes);
        if (layout_if.slice_bytes !== want.slice_bytes)
          note_mismatch("slice_bytes", layout_if.slice_bytes, want.slice_bytes);
        if (layout_if.padded_width !== want.padded_width)
          note_mismatch("padded_width", 32'(layout_if.padded_width), 32'(want.padded_width));
        if (layout_if.padded_height !== want.padded_height)
          note_mismatch("padded_height", 32'(layout_if.padded_height), 32'(want.padded_height));
        if (layout_if.total_bytes !== want.total_bytes)
          note_mismatch("total_bytes", layout_if.total_bytes, want.total_bytes);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (query_if.valid && query_if.ready) || (layout_if.valid && layout_if.ready) ||
        (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int current, burst;
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    query_if.valid = 1'b0;
    query_if.array_index = '0;
    query_if.face = '0;
    query_if.mip_level = '0;
    query_if.depth_index = '0;
    tex_cfg = '{tmco_pkg::RST_TEX_WIDTH, tmco_pkg::RST_TEX_HEIGHT, tmco_pkg::RST_TEX_DEPTH,
                tmco_pkg::RST_MIP_COUNT, tmco_pkg::RST_ARRAY_COUNT, tmco_pkg::RST_CUBE_MAP,
                tmco_pkg::RST_BLOCK_SIZE, tmco_pkg::RST_BPP};

    cfg_table[0] = tex_cfg;
    cfg_table[1] = '{15'd16384, 15'd16384, 12'd2048, 4'd15, 12'd2048, 1'b1, 5'd16, 8'd128};
    cfg_table[2] = '0;
    cfg_table[3] = '{15'd32767, 15'd32767, 12'd4095, 4'd15, 12'd4095, 1'b1, 5'd31, 8'd255};
    cfg_table[4] = '{15'd32767, 15'd255, 12'd7, 4'd4, 12'd0, 1'b0, 5'd2, 8'd8};
    cfg_table[5] = '{15'd300, 15'd200, 12'd9, 4'd6, 12'd3, 1'b1, 5'd4, 8'd0};

    // Reset layout: a single 1x1 mip of 4 bytes.
    directed_rows.push_back(mk_row(0, 0, 0, 0, 0, 1, 0, 4, 4, 1, 1, 4));
    directed_rows.push_back(mk_row(0, 1, 0, 0, 3, 1, 16, 4, 4, 1, 1, 4));
    directed_rows.push_back(mk_row(0, 0, 7, 0, 0, 1, 28, 4, 4, 1, 1, 4));
    directed_rows.push_back(mk_row(0, 2047, 7, 15, 2047, 1, 8216, 0, 0, 0, 0, 4));
    directed_rows.push_back(mk_row(0, 0, 0, 1, 0, 1, 0, 0, 0, 0, 0, 4));
    directed_rows.push_back(mk_row(1, 0, 0, 0, 0, 0));
    directed_rows.push_back(mk_row(1, 2047, 5, 14, 2047, 0));
    directed_rows.push_back(mk_row(1, 5, 3, 7, 100, 0));
    directed_rows.push_back(mk_row(1, 0, 0, 15, 0, 0));
    // With no mips in use every size and offset is zero.
    directed_rows.push_back(mk_row(2, 2047, 5, 0, 2047, 1, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(mk_row(2, 0, 0, 14, 0, 1, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(mk_row(3, 2047, 7, 14, 2047, 0));
    directed_rows.push_back(mk_row(3, 100, 2, 0, 1, 0));
    directed_rows.push_back(mk_row(3, 0, 0, 15, 5, 0));
    directed_rows.push_back(mk_row(4, 0, 0, 0, 0, 0));
    directed_rows.push_back(mk_row(4, 1, 0, 3, 6, 0));
    directed_rows.push_back(mk_row(4, 2047, 0, 4, 0, 0));
    directed_rows.push_back(mk_row(5, 2, 5, 0, 8, 0));
    directed_rows.push_back(mk_row(5, 0, 1, 5, 0, 0));
    directed_rows.push_back(mk_row(5, 3, 6, 2, 1, 0));

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    current = 0;
    foreach (directed_rows[k]) begin
      if (int'(directed_rows[k].setting) != current) begin
        settle();
        current = int'(directed_rows[k].setting);
        apply_setting(cfg_table[current]);
      end
      offer_query(directed_rows[k].query, directed_rows[k].typed, directed_rows[k].layout);
    end

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      settle();
      apply_setting(random_setting());
      if (p == 3) hold_armed = 1'b1;
      burst = $urandom_range(1, 12);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        offer_query(random_query(tex_cfg), 1'b0, '0);
        burst--;
        if (burst == 0) begin
          burst = $urandom_range(1, 12);
          if (p % 3 != 0) pause_sender($urandom_range(1, 8));
        end
      end
    end

    settle();
    repeat (100) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### files.f
+incdir+design
design/tmco_pkg.sv
design/tmco_ifs.sv
design/texture_mip_chain_offset_unit.sv
tb/texture_mip_chain_offset_unit_tb.sv
